// File: rtl/process_ready_queue_selector_unit_macros.svh
// Assertion macros for the process ready-queue selector.
`ifndef PROCESS_READY_QUEUE_SELECTOR_UNIT_MACROS_SVH
`define PROCESS_READY_QUEUE_SELECTOR_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset.
`define PRQS_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("prqs: check failed");
// Next-cycle implication, disabled during reset.
`define PRQS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("prqs: check failed");
`else
`define PRQS_ASSERT_NOW(lbl, clk, rstn, ante, cons)
`define PRQS_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// File: rtl/prqs_pkg.sv
// Shared types and constants for the process ready-queue selector.
package prqs_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int ID_W      = 8;
    localparam int PRIO_W    = 8;
    localparam int TIME_W    = 16;
    localparam int CNT_W     = 5;

    // priority value that a highest-priority select never picks
    localparam logic signed [PRIO_W-1:0] PRIO_NONE = 8'sh80;

    typedef enum logic [3:0] {
        A_INSERT       = 4'd0,
        A_POP          = 4'd1,
        A_REMOVE       = 4'd2,
        A_EARLIEST     = 4'd3,
        A_SHORTEST     = 4'd4,
        A_HIGHEST      = 4'd5,
        A_SHORTEST_ARR = 4'd6,
        A_HIGHEST_ARR  = 4'd7,
        A_PEEK         = 4'd8
    } t_action;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_NONE = 2'd1,
        ST_FULL = 2'd2
    } t_status;

    typedef struct packed {
        logic [TIME_W-1:0]        arrival;
        logic [TIME_W-1:0]        remaining;
        logic signed [PRIO_W-1:0] prio;
        logic [ID_W-1:0]          id;
    } t_entry;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_EMIT
    } t_state;

endpackage

// File: rtl/prqs_pick.sv
// Select comparator: decides whether a scanned entry beats the current best.
module prqs_pick (
    input  prqs_pkg::t_action          i_action,
    input  logic [prqs_pkg::TIME_W-1:0] i_now,
    input  prqs_pkg::t_entry           i_cand,
    input  prqs_pkg::t_entry           i_best,
    input  logic                       i_best_valid,
    output logic                       o_take
);

    logic arrived;
    logic less_arrival;
    logic less_remaining;
    logic more_prio;
    logic prio_ok;

    assign arrived        = i_cand.arrival <= i_now;
    // strict compares: ties keep the entry nearer the head
    assign less_arrival   = !i_best_valid || (i_cand.arrival < i_best.arrival);
    assign less_remaining = !i_best_valid || (i_cand.remaining < i_best.remaining);
    assign more_prio      = !i_best_valid || ($signed(i_cand.prio) > $signed(i_best.prio));
    assign prio_ok        = i_cand.prio != prqs_pkg::PRIO_NONE;

    always_comb begin
        case (i_action)
            prqs_pkg::A_EARLIEST:     o_take = less_arrival;
            prqs_pkg::A_SHORTEST:     o_take = less_remaining;
            prqs_pkg::A_HIGHEST:      o_take = prio_ok && more_prio;
            prqs_pkg::A_SHORTEST_ARR: o_take = arrived && less_remaining;
            prqs_pkg::A_HIGHEST_ARR:  o_take = arrived && prio_ok && more_prio;
            default:                  o_take = 1'b0;
        endcase
    end

endmodule

// File: rtl/process_ready_queue_selector_unit.sv
// Top level of the process ready-queue selector: table memory, sequencer and stream ports.
//
// Keeps an ordered table of up to DEPTH process entries (id, signed priority,
// remaining time, arrival time) in one synchronous memory, head at address 0.
// Each request carries one action in s_axis_tuser and gives exactly one result.
// Insert appends at the tail (status full when no room); pop and peek return the
// head; remove deletes the first entry with the given id; the selects scan for
// the earliest arrival, the least remaining time or the highest priority, the
// last two optionally only among entries already arrived. Ties go to the entry
// nearer the head. Requests are handled one at a time. The single memory read
// port is walked by the scan one entry per cycle, and the close-up after
// pop/remove moves each later entry down one slot per cycle. The finished
// result sits in an output register, so the next request is taken while the
// previous result still waits on m_axis_tready.
`include "process_ready_queue_selector_unit_macros.svh"

module process_ready_queue_selector_unit #(
    parameter int DEPTH = prqs_pkg::DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request channel
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [7:0] process_id, [15:8] priority_req, [31:16] run_time,
    // [47:32] arrival_time, [63:48] current_time
    input  logic [63:0] s_axis_tdata,
    // [3:0] action
    input  logic [3:0]  s_axis_tuser,
    // result channel
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [7:0] result_id, [15:8] result_priority, [31:16] result_remaining,
    // [47:32] result_arrival, [52:48] entry_count, [55:53] zero
    output logic [55:0] m_axis_tdata,
    // [1:0] status
    output logic [1:0]  m_axis_tuser
);

    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int CMPW  = AW + 2;           // common width for index/count compares
    localparam int CNT_W = prqs_pkg::CNT_W;

    // sequencer state
    prqs_pkg::t_state  r_state, n_state;
    logic [CW-1:0]     r_occ, n_occ;
    logic [AW-1:0]     r_idx, n_idx;         // entry whose data is in r_rd_data while scanning
    prqs_pkg::t_action r_action, n_action;
    logic [prqs_pkg::ID_W-1:0]   r_pid, n_pid;
    logic [prqs_pkg::TIME_W-1:0] r_now, n_now;
    prqs_pkg::t_entry  r_best, n_best;
    logic              r_best_valid, n_best_valid;
    prqs_pkg::t_status r_status, n_status;

    // table memory
    prqs_pkg::t_entry  mem [DEPTH];
    prqs_pkg::t_entry  r_rd_data;
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    prqs_pkg::t_entry  mem_wdata;
    logic [AW-1:0]     mem_raddr;

    // output register
    logic              r_out_valid;
    prqs_pkg::t_status r_out_status;
    prqs_pkg::t_entry  r_out_entry;
    logic [CNT_W-1:0]  r_out_count;

    // request unpacking and helpers
    logic                        in_acc;
    prqs_pkg::t_action           in_action;
    prqs_pkg::t_entry            in_entry;
    logic [prqs_pkg::TIME_W-1:0] in_now;
    logic                        out_free;
    logic [AW:0]                 idx_p1;
    logic [AW:0]                 idx_p2;
    logic                        scan_last;
    logic                        shift_more;
    logic                        occ_full;
    logic                        is_scan;
    logic                        id_match;
    logic                        take;

    assign s_axis_tready = (r_state == prqs_pkg::S_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign in_action     = prqs_pkg::t_action'(s_axis_tuser);
    assign in_entry      = prqs_pkg::t_entry'(s_axis_tdata[47:0]);
    assign in_now        = s_axis_tdata[63:48];

    assign out_free   = !r_out_valid || m_axis_tready;
    assign idx_p1     = {1'b0, r_idx} + (AW + 1)'(1);
    assign idx_p2     = {1'b0, r_idx} + (AW + 1)'(2);
    assign scan_last  = CMPW'(idx_p1) == CMPW'(r_occ);
    // during close-up, entry r_idx+1 exists and must move down
    assign shift_more = CMPW'(idx_p1) < CMPW'(r_occ);
    assign occ_full   = CMPW'(r_occ) >= CMPW'(DEPTH);
    assign is_scan    = (r_occ != '0) &&
                        (in_action inside {[prqs_pkg::A_POP : prqs_pkg::A_PEEK]});
    assign id_match   = r_rd_data.id == r_pid;

    prqs_pick u_pick (
        .i_action     (r_action),
        .i_now        (r_now),
        .i_cand       (r_rd_data),
        .i_best       (r_best),
        .i_best_valid (r_best_valid),
        .o_take       (take)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            prqs_pkg::S_IDLE: begin
                if (in_acc) begin
                    n_state = is_scan ? prqs_pkg::S_SCAN : prqs_pkg::S_EMIT;
                end
            end
            prqs_pkg::S_SCAN: begin
                case (r_action)
                    prqs_pkg::A_POP:    n_state = prqs_pkg::S_SHIFT;
                    prqs_pkg::A_PEEK:   n_state = prqs_pkg::S_EMIT;
                    prqs_pkg::A_REMOVE: begin
                        if (id_match) begin
                            n_state = prqs_pkg::S_SHIFT;
                        end else if (scan_last) begin
                            n_state = prqs_pkg::S_EMIT;
                        end
                    end
                    default: begin
                        if (scan_last) begin
                            n_state = prqs_pkg::S_EMIT;
                        end
                    end
                endcase
            end
            prqs_pkg::S_SHIFT: begin
                if (!shift_more) begin
                    n_state = prqs_pkg::S_EMIT;
                end
            end
            prqs_pkg::S_EMIT: begin
                if (out_free) begin
                    n_state = prqs_pkg::S_IDLE;
                end
            end
            default: n_state = prqs_pkg::S_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb begin
        n_occ        = r_occ;
        n_idx        = r_idx;
        n_action     = r_action;
        n_pid        = r_pid;
        n_now        = r_now;
        n_best       = r_best;
        n_best_valid = r_best_valid;
        n_status     = r_status;
        mem_we       = 1'b0;
        mem_waddr    = r_idx;
        mem_wdata    = r_rd_data;
        mem_raddr    = idx_p1[AW-1:0];
        case (r_state)
            prqs_pkg::S_IDLE: begin
                mem_raddr = '0;                  // head, for any scan that follows
                if (in_acc) begin
                    n_action     = in_action;
                    n_pid        = in_entry.id;
                    n_now        = in_now;
                    n_idx        = '0;
                    n_best_valid = 1'b0;
                    n_status     = prqs_pkg::ST_NONE;
                    if (in_action == prqs_pkg::A_INSERT) begin
                        if (occ_full) begin
                            n_status = prqs_pkg::ST_FULL;
                        end else begin
                            mem_we    = 1'b1;
                            mem_waddr = r_occ[AW-1:0];
                            mem_wdata = in_entry;
                            n_occ     = r_occ + CW'(1);
                            n_status  = prqs_pkg::ST_OK;
                        end
                    end
                end
            end
            prqs_pkg::S_SCAN: begin
                case (r_action)
                    prqs_pkg::A_POP, prqs_pkg::A_PEEK: begin
                        n_best       = r_rd_data;
                        n_best_valid = 1'b1;
                        n_status     = prqs_pkg::ST_OK;
                    end
                    prqs_pkg::A_REMOVE: begin
                        if (id_match) begin
                            n_best       = r_rd_data;
                            n_best_valid = 1'b1;
                            n_status     = prqs_pkg::ST_OK;
                        end else begin
                            n_idx = idx_p1[AW-1:0];
                        end
                    end
                    default: begin
                        if (take) begin
                            n_best       = r_rd_data;
                            n_best_valid = 1'b1;
                        end
                        if (scan_last) begin
                            n_status = (r_best_valid || take) ? prqs_pkg::ST_OK
                                                              : prqs_pkg::ST_NONE;
                        end
                        n_idx = idx_p1[AW-1:0];
                    end
                endcase
            end
            prqs_pkg::S_SHIFT: begin
                // r_rd_data holds entry r_idx+1; write it to r_idx, fetch r_idx+2
                mem_raddr = idx_p2[AW-1:0];
                if (shift_more) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_idx;
                    mem_wdata = r_rd_data;
                    n_idx     = idx_p1[AW-1:0];
                end else begin
                    n_occ = r_occ - CW'(1);
                end
            end
            default: begin
            end
        endcase
    end

    // table memory, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        r_rd_data <= mem[mem_raddr];
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= prqs_pkg::S_IDLE;
            r_occ       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_occ   <= n_occ;
            if (r_state == prqs_pkg::S_EMIT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_idx        <= n_idx;
        r_action     <= n_action;
        r_pid        <= n_pid;
        r_now        <= n_now;
        r_best       <= n_best;
        r_best_valid <= n_best_valid;
        r_status     <= n_status;
        if (r_state == prqs_pkg::S_EMIT && out_free) begin
            r_out_status <= r_status;
            // only a reported entry shows its fields; everything else reads zero
            r_out_entry  <= r_best_valid ? r_best : '0;
            r_out_count  <= CNT_W'(r_occ);
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'b000, r_out_count, r_out_entry};
    assign m_axis_tuser  = r_out_status;

    `PRQS_ASSERT_NOW(a_occ_bound, i_clk, i_rst_n, 1'b1, CMPW'(r_occ) <= CMPW'(DEPTH))
    `PRQS_ASSERT_NEXT(a_insert_grows, i_clk, i_rst_n,
        in_acc && (in_action == prqs_pkg::A_INSERT) && !occ_full,
        r_occ == $past(r_occ) + CW'(1))
    `PRQS_ASSERT_NOW(a_shift_in_range, i_clk, i_rst_n,
        (r_state == prqs_pkg::S_SHIFT) && mem_we, CMPW'(idx_p1) < CMPW'(r_occ))
    `PRQS_ASSERT_NOW(a_result_from_emit, i_clk, i_rst_n,
        $rose(m_axis_tvalid), $past(r_state) == prqs_pkg::S_EMIT)
    `PRQS_ASSERT_NEXT(a_emit_delivers, i_clk, i_rst_n,
        (r_state == prqs_pkg::S_EMIT) && out_free,
        m_axis_tvalid && (r_state == prqs_pkg::S_IDLE))

endmodule

// File: dv/tb_top.sv
// Self-checking testbench for the process ready-queue selector top level.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import prqs_pkg::*;

    localparam int          N_ITEMS     = 900;
    localparam int          CYCLE_LIMIT = 400000;
    localparam int          LONG_HOLD   = 300;
    localparam int          DRAIN_WAIT  = 2 * DEPTH_DEF + 8;
    localparam logic [3:0]  ACT_BAD_LO  = 4'd9;
    localparam logic [3:0]  ACT_BAD_HI  = 4'd15;
    localparam t_entry      NO_ENTRY    = '0;
    localparam logic [15:0] T_MAX       = 16'hFFFF;

    // one request as it travels on the slave side
    typedef struct packed {
        logic [3:0]  act;
        logic [15:0] cur_time;
        t_entry      ent;
    } t_request;

    // one result as it should leave the master side
    typedef struct packed {
        t_status    status;
        t_entry     rep;
        logic [4:0] count;
    } t_result;

    typedef struct packed {
        bit       typed;
        t_result  res;
        t_request rq;
    } t_row;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata  = '0;
    logic [3:0]  s_axis_tuser  = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [55:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;

    // toggled by the stimulus to ask the receiver for one long hold-off
    logic        hold_ask = 1'b0;

    // predicted table contents, head at index 0
    t_entry      ready_tbl [DEPTH_DEF];
    int          ready_cnt = 0;
    t_result     results_due[$];
    int          fail_count = 0;
    int          burst_left = 0;
    int          sent_count = 0;

    process_ready_queue_selector_unit #(.DEPTH(DEPTH_DEF)) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        forever begin
            #5 i_clk = ~i_clk;
        end
    end

    // ------------------------------------------------------------------
    // Predictor: applies one request to the local table, returns the result
    // ------------------------------------------------------------------
    function automatic t_result apply_request(t_request rq);
        t_result res;
        int      best;
        int      best_key;
        int      key;
        bit      skip;
        res.status = ST_NONE;
        res.rep    = NO_ENTRY;
        best       = -1;
        best_key   = 0;
        case (rq.act)
            A_INSERT: begin
                if (ready_cnt >= DEPTH_DEF) begin
                    res.status = ST_FULL;
                end else begin
                    ready_tbl[ready_cnt] = rq.ent;
                    ready_cnt++;
                    res.status = ST_OK;
                end
            end
            A_POP, A_REMOVE: begin
                // pop takes the head; remove the first id match
                for (int k = 0; k < ready_cnt; k++) begin
                    if (best < 0 && (rq.act == A_POP || ready_tbl[k].id == rq.ent.id))
                        best = k;
                end
                if (best >= 0) begin
                    res.rep    = ready_tbl[best];
                    res.status = ST_OK;
                    for (int k = best; k + 1 < ready_cnt; k++)
                        ready_tbl[k] = ready_tbl[k + 1];
                    ready_cnt--;
                end
            end
            A_EARLIEST, A_SHORTEST, A_HIGHEST, A_SHORTEST_ARR, A_HIGHEST_ARR: begin
                for (int k = 0; k < ready_cnt; k++) begin
                    skip = 1'b0;
                    if ((rq.act == A_SHORTEST_ARR || rq.act == A_HIGHEST_ARR) &&
                        ready_tbl[k].arrival > rq.cur_time)
                        skip = 1'b1;
                    if (rq.act == A_EARLIEST)
                        key = -int'(ready_tbl[k].arrival);
                    else if (rq.act == A_SHORTEST || rq.act == A_SHORTEST_ARR)
                        key = -int'(ready_tbl[k].remaining);
                    else begin
                        key = int'(ready_tbl[k].prio);
                        // the lowest priority code is never picked
                        if (ready_tbl[k].prio == PRIO_NONE)
                            skip = 1'b1;
                    end
                    // strict compare keeps the entry nearest the head on ties
                    if (!skip && (best < 0 || key > best_key)) begin
                        best     = k;
                        best_key = key;
                    end
                end
                if (best >= 0) begin
                    res.rep    = ready_tbl[best];
                    res.status = ST_OK;
                end
            end
            A_PEEK: begin
                if (ready_cnt > 0) begin
                    res.rep    = ready_tbl[0];
                    res.status = ST_OK;
                end
            end
            default: ;
        endcase
        res.count = 5'(ready_cnt);
        return res;
    endfunction

    function automatic t_entry mk_entry(logic [7:0] id, logic signed [7:0] prio,
                                        logic [15:0] remaining, logic [15:0] arrival);
        t_entry e;
        e.id        = id;
        e.prio      = prio;
        e.remaining = remaining;
        e.arrival   = arrival;
        return e;
    endfunction

    function automatic t_row pred_row(logic [3:0] act, t_entry ent, logic [15:0] cur_time);
        t_row r;
        r.typed       = 1'b0;
        r.res         = '0;
        r.rq.act      = act;
        r.rq.ent      = ent;
        r.rq.cur_time = cur_time;
        return r;
    endfunction

    function automatic t_row typed_row(logic [3:0] act, t_entry ent, logic [15:0] cur_time,
                                       t_status st, t_entry rep, logic [4:0] count);
        t_row r;
        r            = pred_row(act, ent, cur_time);
        r.typed      = 1'b1;
        r.res.status = st;
        r.res.rep    = rep;
        r.res.count  = count;
        return r;
    endfunction

    // skewed field values: extremes and narrow ranges give plenty of ties
    function automatic logic [15:0] rand_time();
        case ($urandom_range(0, 9))
            0:       return 16'd0;
            1:       return T_MAX;
            2, 3, 4: return 16'($urandom_range(0, 20));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic t_entry rand_entry();
        t_entry e;
        e.id = ($urandom_range(0, 9) < 7) ? 8'($urandom_range(0, 15)) : 8'($urandom);
        case ($urandom_range(0, 9))
            0:          e.prio = PRIO_NONE;
            1:          e.prio = 8'sd127;
            2:          e.prio = -8'sd127;
            3, 4, 5, 6: e.prio = 8'($urandom_range(0, 6) - 3);
            default:    e.prio = 8'($urandom);
        endcase
        e.remaining = rand_time();
        e.arrival   = rand_time();
        return e;
    endfunction

    // ------------------------------------------------------------------
    // Sender: one request, held until accepted, then burst/gap bookkeeping
    // ------------------------------------------------------------------
    task automatic send_request(t_request rq, bit typed, t_result typed_res);
        t_result res;
        int      gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {rq.cur_time, rq.ent};
        s_axis_tuser  <= rq.act;
        do @(posedge i_clk); while (!s_axis_tready);
        res = apply_request(rq);
        results_due.push_back(typed ? typed_res : res);
        sent_count++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            case ($urandom_range(0, 9))
                0, 1, 2: gap = 0;
                3:       gap = $urandom_range(20, 60);
                default: gap = $urandom_range(1, 8);
            endcase
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(0, 20);
        end
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        wait (results_due.size() == 0);
        @(posedge i_clk);
    endtask

    function automatic t_request rand_request(int target);
        t_request rq;
        int       r;
        rq.ent      = rand_entry();
        rq.cur_time = rand_time();
        r           = $urandom_range(0, 99);
        // fill towards the segment's target, then mostly work the table
        if (r < ((ready_cnt < target) ? 60 : 12)) begin
            rq.act = A_INSERT;
        end else begin
            case ($urandom_range(0, 19))
                0, 1, 2:    rq.act = A_POP;
                3, 4, 5, 6: rq.act = A_REMOVE;
                7, 8:       rq.act = A_EARLIEST;
                9, 10:      rq.act = A_SHORTEST;
                11, 12:     rq.act = A_HIGHEST;
                13, 14:     rq.act = A_SHORTEST_ARR;
                15, 16:     rq.act = A_HIGHEST_ARR;
                17, 18:     rq.act = A_PEEK;
                default:    rq.act = 4'($urandom_range(ACT_BAD_LO, ACT_BAD_HI));
            endcase
        end
        // removes mostly name an id that is stored
        if (rq.act == A_REMOVE && ready_cnt > 0 && $urandom_range(0, 9) < 7)
            rq.ent.id = ready_tbl[$urandom_range(0, ready_cnt - 1)].id;
        return rq;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin
        t_row     dir_rows [27];
        t_entry   top_ent;
        t_entry   floor_ent;
        t_request rq;
        int       target;
        int       seg_left;

        top_ent   = mk_entry(8'hFF, 8'sd127, T_MAX, T_MAX);
        floor_ent = mk_entry(8'h00, PRIO_NONE, 16'd0, 16'd0);
        dir_rows = '{
            // empty table: everything but insert finds nothing
            typed_row(A_POP,          NO_ENTRY, 16'd0, ST_NONE, NO_ENTRY, 5'd0),
            typed_row(A_PEEK,         NO_ENTRY, 16'd0, ST_NONE, NO_ENTRY, 5'd0),
            typed_row(A_EARLIEST,     NO_ENTRY, 16'd0, ST_NONE, NO_ENTRY, 5'd0),
            typed_row(A_SHORTEST,     NO_ENTRY, 16'd0, ST_NONE, NO_ENTRY, 5'd0),
            typed_row(A_HIGHEST,      NO_ENTRY, 16'd0, ST_NONE, NO_ENTRY, 5'd0),
            typed_row(A_SHORTEST_ARR, NO_ENTRY, T_MAX, ST_NONE, NO_ENTRY, 5'd0),
            typed_row(A_HIGHEST_ARR,  NO_ENTRY, T_MAX, ST_NONE, NO_ENTRY, 5'd0),
            typed_row(A_REMOVE, mk_entry(8'd5, 8'sd0, 16'd0, 16'd0), 16'd0,
                      ST_NONE, NO_ENTRY, 5'd0),
            typed_row(ACT_BAD_HI,     top_ent,  T_MAX, ST_NONE, NO_ENTRY, 5'd0),
            // single entry at the top extremes, removed again: reports found
            typed_row(A_INSERT,       top_ent,  16'd0, ST_OK,   NO_ENTRY, 5'd1),
            typed_row(A_REMOVE,       top_ent,  16'd0, ST_OK,   top_ent,  5'd0),
            // lowest priority entry is never a highest-priority pick
            typed_row(A_INSERT,       floor_ent, 16'd0, ST_OK,   NO_ENTRY, 5'd1),
            typed_row(A_HIGHEST,      NO_ENTRY, 16'd0, ST_NONE, NO_ENTRY, 5'd1),
            typed_row(A_HIGHEST_ARR,  NO_ENTRY, T_MAX, ST_NONE, NO_ENTRY, 5'd1),
            pred_row(A_INSERT, mk_entry(8'd1, -8'sd127, 16'd10, 16'd100), 16'd0),
            pred_row(A_INSERT, mk_entry(8'd2, 8'sd5, 16'd10, 16'd50), 16'd0),
            pred_row(A_INSERT, mk_entry(8'd2, 8'sd5, 16'd3, 16'd50), 16'd0),
            pred_row(A_EARLIEST,     NO_ENTRY, 16'd0),
            pred_row(A_SHORTEST,     NO_ENTRY, 16'd0),
            pred_row(A_HIGHEST,      NO_ENTRY, 16'd0),
            pred_row(A_SHORTEST_ARR, NO_ENTRY, 16'd49),
            // nothing arrived apart from the lowest priority entry
            pred_row(A_HIGHEST_ARR,  NO_ENTRY, 16'd49),
            pred_row(A_REMOVE, mk_entry(8'd2, 8'sd0, 16'd0, 16'd0), 16'd0),
            pred_row(A_REMOVE, mk_entry(8'd77, 8'sd0, 16'd0, 16'd0), 16'd0),
            pred_row(A_PEEK,         NO_ENTRY, 16'd0),
            pred_row(A_POP,          NO_ENTRY, 16'd0),
            pred_row(ACT_BAD_LO,     top_ent,  16'd0)
        };

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i])
            send_request(dir_rows[i].rq, dir_rows[i].typed, dir_rows[i].res);
        drain_results();

        // receiver holds off while a run of inserts overfills the table
        hold_ask <= ~hold_ask;
        repeat (DEPTH_DEF + 24) begin
            rq.act      = A_INSERT;
            rq.ent      = rand_entry();
            rq.cur_time = rand_time();
            send_request(rq, 1'b0, '0);
        end
        drain_results();

        while (sent_count < N_ITEMS) begin
            target   = ($urandom_range(0, 3) == 0) ? DEPTH_DEF + 2 : $urandom_range(0, DEPTH_DEF);
            seg_left = $urandom_range(30, 60);
            while (seg_left > 0 && sent_count < N_ITEMS) begin
                send_request(rand_request(target), 1'b0, '0);
                seg_left--;
            end
            // now and then the sender waits for every result to come back
            if ($urandom_range(0, 3) == 0)
                drain_results();
        end

        drain_results();
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // ------------------------------------------------------------------
    // Receiver: own stall pattern, plus one long hold-off on request
    // ------------------------------------------------------------------
    initial begin
        int   hold_left;
        int   mode;
        int   mode_left;
        logic seen_ask;
        hold_left = 0;
        mode      = 0;
        mode_left = 0;
        seen_ask  = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_ask != seen_ask) begin
                seen_ask  = hold_ask;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode      = $urandom_range(0, 3);
                    mode_left = $urandom_range(20, 200);
                end
                mode_left--;
                case (mode)
                    0:       m_axis_tready <= 1'b1;
                    1:       m_axis_tready <= 1'($urandom_range(0, 1));
                    2:       m_axis_tready <= ($urandom_range(0, 3) == 0);
                    default: m_axis_tready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Result checker: oldest expectation against each accepted result
    // ------------------------------------------------------------------
    task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_result want;
        t_entry  got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (results_due.size() == 0) begin
                $display("%0t: result with none expected, actual %0h/%0h",
                         $time, m_axis_tuser, m_axis_tdata);
                fail_count++;
            end else begin
                want = results_due.pop_front();
                got  = m_axis_tdata[47:0];
                check_field("status",    16'(want.status),        16'(m_axis_tuser));
                check_field("id",        16'(want.rep.id),        16'(got.id));
                check_field("priority",  16'(want.rep.prio),      16'(got.prio));
                check_field("remaining", want.rep.remaining,      got.remaining);
                check_field("arrival",   want.rep.arrival,        got.arrival);
                check_field("count",     16'(want.count),         16'(m_axis_tdata[52:48]));
                check_field("pad",       16'd0,                   16'(m_axis_tdata[55:53]));
            end
        end
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("%0t: timeout, %0d results outstanding", $time, results_due.size());
        $display("Test completed with failures");
        $finish;
    end

endmodule

// File: sim.f
+incdir+rtl
rtl/prqs_pkg.sv
rtl/prqs_pick.sv
rtl/process_ready_queue_selector_unit.sv
dv/tb_top.sv
